>>> src/tmh_pkg.sv
// Package for the timer min-heap: sizes, command and status codes,
// datapath operation codes, and the structs shared by the modules. No dependencies.
`timescale 1ns / 1ps

package tmh_pkg;

   localparam int CAPACITY    = 64;
   localparam int HANDLE_BITS = 6;
   localparam int POS_BITS    = 7;   // heap positions 1..CAPACITY
   localparam int COUNT_BITS  = 7;   // 0..CAPACITY
   localparam int TIME_BITS   = 48;
   localparam int TAG_BITS    = 32;
   localparam int HEAP_DEPTH  = CAPACITY + 1;
   localparam int GROUPS      = CAPACITY / 8;
   localparam int GROUP_BITS  = 3;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_EXPIRE = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_INVALID = 2'd2,
      ST_NONE    = 2'd3
   } rsp_status_type;

   // One heap slot: the timer handle and its expiry key.
   typedef struct packed {
      logic [HANDLE_BITS-1:0] handle;
      logic [TIME_BITS-1:0]   key;
   } heap_entry_type;

   // One buffered result, before the step-wide fields are attached.
   typedef struct packed {
      rsp_status_type         status;
      logic [HANDLE_BITS-1:0] handle;
      logic [TAG_BITS-1:0]    tag;
   } result_entry_type;

   // Datapath operations issued by the controller.
   typedef enum logic [4:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_PUSH_FULL,
      OP_PUSH_BAD,
      OP_PUSH_NULL,
      OP_PUSH_NONE,
      OP_READ_POS,
      OP_ALLOC_GRP,
      OP_ALLOC_SET,
      OP_UP_READ,
      OP_MOVE_PARENT,
      OP_PLACE,
      OP_DEL_POS,
      OP_READ_LAST,
      OP_COUNT_DEC,
      OP_TAKE_LAST,
      OP_READ_LEFT,
      OP_TAKE_LEFT,
      OP_TAKE_RIGHT,
      OP_MOVE_CHILD,
      OP_READ_ROOT,
      OP_TAKE_ROOT,
      OP_PUSH_EXPIRED,
      OP_TAKE_EARLIEST,
      OP_READ_BUF,
      OP_LOAD_OUT,
      OP_NEXT_IDX
   } dp_op_type;

   // Flags from the datapath back to the controller.
   typedef struct packed {
      cmd_type cmd;
      logic    count_full;
      logic    count_zero;
      logic    handle_live;
      logic    hole_is_root;
      logic    hole_lt_count;
      logic    up_less;
      logic    kid_gt_count;
      logic    kid_lt_count;
      logic    down_stop;
      logic    root_late;
      logic    n_full;
      logic    n_zero;
      logic    last_item;
   } dp_status_type;

endpackage

>>> src/tmh_if.sv
// Valid/ready channel interfaces for the request and response items.
// Depends on tmh_pkg.
`timescale 1ns / 1ps

interface tmh_req_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     cmd;
   logic [tmh_pkg::TIME_BITS-1:0]  expire_time;
   logic [tmh_pkg::TAG_BITS-1:0]   user_tag;
   logic [tmh_pkg::HANDLE_BITS-1:0] timer_handle;
   logic [tmh_pkg::TIME_BITS-1:0]  now_time;

   modport source (output valid, cmd, expire_time, user_tag, timer_handle, now_time,
                   input ready);
   modport sink   (input valid, cmd, expire_time, user_tag, timer_handle, now_time,
                   output ready);
endinterface

interface tmh_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      status;
   logic [tmh_pkg::HANDLE_BITS-1:0] result_handle;
   logic [tmh_pkg::TAG_BITS-1:0]    expired_tag;
   logic [tmh_pkg::TIME_BITS-1:0]   earliest_time;
   logic [tmh_pkg::COUNT_BITS-1:0]  timer_count;
   logic                            last;

   modport source (output valid, status, result_handle, expired_tag, earliest_time,
                   timer_count, last, input ready);
   modport sink   (input valid, status, result_handle, expired_tag, earliest_time,
                   timer_count, last, output ready);
endinterface

>>> src/tmh_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tmh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/tmh_datapath.sv
// Datapath of the timer heap: heap, position, tag and result memories,
// live map, counters and output registers. Depends on tmh_pkg, tmh_ram.
`timescale 1ns / 1ps

module tmh_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  tmh_pkg::dp_op_type              op,
   input  logic [1:0]                      req_cmd,
   input  logic [tmh_pkg::TIME_BITS-1:0]   req_expire_time,
   input  logic [tmh_pkg::TAG_BITS-1:0]    req_user_tag,
   input  logic [tmh_pkg::HANDLE_BITS-1:0] req_timer_handle,
   input  logic [tmh_pkg::TIME_BITS-1:0]   req_now_time,
   output tmh_pkg::dp_status_type          status,
   output logic [1:0]                      rsp_status,
   output logic [tmh_pkg::HANDLE_BITS-1:0] rsp_result_handle,
   output logic [tmh_pkg::TAG_BITS-1:0]    rsp_expired_tag,
   output logic [tmh_pkg::TIME_BITS-1:0]   rsp_earliest_time,
   output logic [tmh_pkg::COUNT_BITS-1:0]  rsp_timer_count,
   output logic                            rsp_last
);
   import tmh_pkg::*;

   localparam int HEAP_W = $bits(heap_entry_type);
   localparam int RES_W  = $bits(result_entry_type);

   // control registers
   logic [CAPACITY-1:0]    live_ff, live_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   // payload registers
   cmd_type                cmd_ff, cmd_in;
   logic [TIME_BITS-1:0]   time_ff, time_in;
   logic [TAG_BITS-1:0]    tag_ff, tag_in;
   logic [HANDLE_BITS-1:0] hdl_ff, hdl_in;
   heap_entry_type         cur_ff, cur_in;
   heap_entry_type         pick_ff, pick_in;
   logic [POS_BITS-1:0]    pick_pos_ff, pick_pos_in;
   logic [POS_BITS-1:0]    hole_ff, hole_in;
   logic [COUNT_BITS-1:0]  n_ff, n_in;
   logic [HANDLE_BITS-1:0] idx_ff, idx_in;
   logic [GROUP_BITS-1:0]  grp_ff, grp_in;
   logic [TIME_BITS-1:0]   earliest_ff, earliest_in;
   result_entry_type       out_ff, out_in;
   logic                   last_ff, last_in;

   // memory ports
   logic                   heap_we;
   logic [POS_BITS-1:0]    heap_waddr, heap_raddr;
   heap_entry_type         heap_wdata, heap_rd;
   logic                   pos_we;
   logic [HANDLE_BITS-1:0] pos_waddr, pos_raddr;
   logic [POS_BITS-1:0]    pos_wdata, pos_rd;
   logic                   tag_we;
   logic [HANDLE_BITS-1:0] tag_waddr, tag_raddr;
   logic [TAG_BITS-1:0]    tag_rd;
   logic                   buf_we;
   logic [HANDLE_BITS-1:0] buf_raddr;
   result_entry_type       buf_wdata, buf_rd;

   logic [POS_BITS:0]      kid;
   logic [POS_BITS:0]      kid_r;
   logic [HANDLE_BITS-1:0] new_h;
   logic [GROUP_BITS-1:0]  free_grp;
   logic [2:0]             free_bit;
   logic [7:0]             grp_bits;

   tmh_ram #(.WIDTH(HEAP_W), .DEPTH(HEAP_DEPTH)) u_heap (
      .clock(clock), .wr_en(heap_we), .wr_addr(heap_waddr), .wr_data(heap_wdata),
      .rd_addr(heap_raddr), .rd_data(heap_rd)
   );
   tmh_ram #(.WIDTH(POS_BITS), .DEPTH(CAPACITY)) u_pos (
      .clock(clock), .wr_en(pos_we), .wr_addr(pos_waddr), .wr_data(pos_wdata),
      .rd_addr(pos_raddr), .rd_data(pos_rd)
   );
   tmh_ram #(.WIDTH(TAG_BITS), .DEPTH(CAPACITY)) u_tag (
      .clock(clock), .wr_en(tag_we), .wr_addr(tag_waddr), .wr_data(tag_ff),
      .rd_addr(tag_raddr), .rd_data(tag_rd)
   );
   tmh_ram #(.WIDTH(RES_W), .DEPTH(CAPACITY)) u_buf (
      .clock(clock), .wr_en(buf_we), .wr_addr(n_ff[HANDLE_BITS-1:0]),
      .wr_data(buf_wdata), .rd_addr(buf_raddr), .rd_data(buf_rd)
   );

   // children of the hole
   assign kid   = {hole_ff, 1'b0};
   assign kid_r = kid + 1'b1;

   // lowest group of eight handles with a free one
   always_comb begin
      free_grp = '0;
      for (int g = GROUPS - 1; g >= 0; g--) begin
         if (live_ff[g*8 +: 8] != 8'hFF) begin
            free_grp = GROUP_BITS'(g);
         end
      end
   end

   // lowest free handle within the chosen group
   assign grp_bits = live_ff[grp_ff*8 +: 8];
   always_comb begin
      free_bit = '0;
      for (int b = 7; b >= 0; b--) begin
         if (!grp_bits[b]) begin
            free_bit = 3'(b);
         end
      end
   end
   assign new_h = {grp_ff, free_bit};

   // status flags
   always_comb begin
      status.cmd           = cmd_ff;
      status.count_full    = (count_ff == COUNT_BITS'(CAPACITY));
      status.count_zero    = (count_ff == '0);
      status.handle_live   = live_ff[hdl_ff];
      status.hole_is_root  = (hole_ff == POS_BITS'(1));
      status.hole_lt_count = (hole_ff < count_ff);
      status.up_less       = (cur_ff.key < heap_rd.key);
      status.kid_gt_count  = (kid > {1'b0, count_ff});
      status.kid_lt_count  = (kid < {1'b0, count_ff});
      status.down_stop     = (cur_ff.key < pick_ff.key);
      status.root_late     = (heap_rd.key > time_ff);
      status.n_full        = (n_ff == COUNT_BITS'(CAPACITY));
      status.n_zero        = (n_ff == '0);
      status.last_item     = (({1'b0, idx_ff} + 1'b1) == n_ff);
   end

   // operation decode
   always_comb begin
      live_in     = live_ff;
      count_in    = count_ff;
      cmd_in      = cmd_ff;
      time_in     = time_ff;
      tag_in      = tag_ff;
      hdl_in      = hdl_ff;
      cur_in      = cur_ff;
      pick_in     = pick_ff;
      pick_pos_in = pick_pos_ff;
      hole_in     = hole_ff;
      n_in        = n_ff;
      idx_in      = idx_ff;
      grp_in      = grp_ff;
      earliest_in = earliest_ff;
      out_in      = out_ff;
      last_in     = last_ff;
      heap_we     = 1'b0;
      heap_waddr  = hole_ff;
      heap_wdata  = cur_ff;
      heap_raddr  = POS_BITS'(1);
      pos_we      = 1'b0;
      pos_waddr   = cur_ff.handle;
      pos_wdata   = hole_ff;
      pos_raddr   = hdl_ff;
      tag_we      = 1'b0;
      tag_waddr   = new_h;
      tag_raddr   = heap_rd.handle;
      buf_we      = 1'b0;
      buf_wdata   = '{status: ST_OK, handle: '0, tag: '0};
      buf_raddr   = idx_ff;
      unique case (op)
         OP_CAPTURE: begin
            cmd_in  = cmd_type'(req_cmd);
            time_in = (cmd_type'(req_cmd) == CMD_EXPIRE) ? req_now_time : req_expire_time;
            tag_in  = req_user_tag;
            hdl_in  = req_timer_handle;
            n_in    = '0;
         end
         OP_PUSH_FULL: begin
            buf_we           = 1'b1;
            buf_wdata.status = ST_FULL;
            n_in             = n_ff + 1'b1;
         end
         OP_PUSH_BAD: begin
            buf_we           = 1'b1;
            buf_wdata.status = ST_INVALID;
            buf_wdata.handle = hdl_ff;
            n_in             = n_ff + 1'b1;
         end
         OP_PUSH_NULL: begin
            buf_we = 1'b1;
            n_in   = n_ff + 1'b1;
         end
         OP_PUSH_NONE: begin
            buf_we           = 1'b1;
            buf_wdata.status = ST_NONE;
            n_in             = n_ff + 1'b1;
         end
         OP_READ_POS: begin
            pos_raddr = hdl_ff;
         end
         OP_ALLOC_GRP: begin
            grp_in = free_grp;
         end
         OP_ALLOC_SET: begin
            cur_in.handle    = new_h;
            cur_in.key       = time_ff;
            live_in[new_h]   = 1'b1;
            count_in         = count_ff + 1'b1;
            hole_in          = POS_BITS'(count_ff + 1'b1);
            tag_we           = 1'b1;
            tag_waddr        = new_h;
            buf_we           = 1'b1;
            buf_wdata.handle = new_h;
            n_in             = n_ff + 1'b1;
         end
         OP_UP_READ: begin
            heap_raddr = hole_ff >> 1;
         end
         OP_MOVE_PARENT: begin
            heap_we    = 1'b1;
            heap_waddr = hole_ff;
            heap_wdata = heap_rd;
            pos_we     = 1'b1;
            pos_waddr  = heap_rd.handle;
            pos_wdata  = hole_ff;
            hole_in    = hole_ff >> 1;
         end
         OP_PLACE: begin
            heap_we    = 1'b1;
            heap_waddr = hole_ff;
            heap_wdata = cur_ff;
            pos_we     = 1'b1;
            pos_waddr  = cur_ff.handle;
            pos_wdata  = hole_ff;
         end
         OP_DEL_POS: begin
            hole_in          = pos_rd;
            live_in[hdl_ff]  = 1'b0;
            buf_we           = 1'b1;
            buf_wdata.handle = hdl_ff;
            n_in             = n_ff + 1'b1;
         end
         OP_READ_LAST: begin
            heap_raddr = count_ff;
         end
         OP_COUNT_DEC: begin
            count_in = count_ff - 1'b1;
         end
         OP_TAKE_LAST: begin
            cur_in     = heap_rd;
            count_in   = count_ff - 1'b1;
            heap_raddr = hole_ff >> 1;
         end
         OP_READ_LEFT: begin
            heap_raddr = kid[POS_BITS-1:0];
         end
         OP_TAKE_LEFT: begin
            pick_in     = heap_rd;
            pick_pos_in = kid[POS_BITS-1:0];
            heap_raddr  = kid_r[POS_BITS-1:0];
         end
         OP_TAKE_RIGHT: begin
            if (heap_rd.key < pick_ff.key) begin
               pick_in     = heap_rd;
               pick_pos_in = kid_r[POS_BITS-1:0];
            end
         end
         OP_MOVE_CHILD: begin
            heap_we    = 1'b1;
            heap_waddr = hole_ff;
            heap_wdata = pick_ff;
            pos_we     = 1'b1;
            pos_waddr  = pick_ff.handle;
            pos_wdata  = hole_ff;
            hole_in    = pick_pos_ff;
         end
         OP_READ_ROOT: begin
            heap_raddr = POS_BITS'(1);
         end
         OP_TAKE_ROOT: begin
            cur_in                 = heap_rd;
            live_in[heap_rd.handle] = 1'b0;
            hole_in                = POS_BITS'(1);
            tag_raddr              = heap_rd.handle;
         end
         OP_PUSH_EXPIRED: begin
            buf_we           = 1'b1;
            buf_wdata.handle = cur_ff.handle;
            buf_wdata.tag    = tag_rd;
            n_in             = n_ff + 1'b1;
         end
         OP_TAKE_EARLIEST: begin
            earliest_in = (count_ff == '0) ? '0 : heap_rd.key;
            idx_in      = '0;
         end
         OP_READ_BUF: begin
            buf_raddr = idx_ff;
         end
         OP_LOAD_OUT: begin
            out_in  = buf_rd;
            last_in = status.last_item;
         end
         OP_NEXT_IDX: begin
            idx_in = idx_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   // control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff  <= '0;
         count_ff <= '0;
      end else begin
         live_ff  <= live_in;
         count_ff <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      time_ff     <= time_in;
      tag_ff      <= tag_in;
      hdl_ff      <= hdl_in;
      cur_ff      <= cur_in;
      pick_ff     <= pick_in;
      pick_pos_ff <= pick_pos_in;
      hole_ff     <= hole_in;
      n_ff        <= n_in;
      idx_ff      <= idx_in;
      grp_ff      <= grp_in;
      earliest_ff <= earliest_in;
      out_ff      <= out_in;
      last_ff     <= last_in;
   end

   assign rsp_status        = out_ff.status;
   assign rsp_result_handle = out_ff.handle;
   assign rsp_expired_tag   = out_ff.tag;
   assign rsp_earliest_time = earliest_ff;
   assign rsp_timer_count   = count_ff;
   assign rsp_last          = last_ff;

endmodule

>>> src/tmh_ctrl.sv
// Controller of the timer heap: sequences add, delete, expire and the
// result drain. Depends on tmh_pkg.
`timescale 1ns / 1ps

module tmh_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  tmh_pkg::dp_status_type status,
   output tmh_pkg::dp_op_type     op
);
   import tmh_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_ALLOC1, S_ALLOC2, S_UP_READ, S_UP_CMP, S_PLACE,
      S_DEL_POS, S_REMOVE, S_RM_LAST, S_RM_PAR, S_DOWN_L, S_DOWN_R, S_DOWN_RC,
      S_DOWN_CMP, S_EXP_CHECK, S_EXP_ROOT, S_EXP_TAG, S_EXP_END, S_FINISH,
      S_FIN_KEY, S_EMIT_RD, S_EMIT_LD, S_EMIT_WAIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   state_type done_state;

   // where a finished heap update goes next
   assign done_state = (status.cmd == CMD_EXPIRE) ? S_EXP_CHECK : S_FINISH;

   // next state and datapath operation
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      op           = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op       = OP_CAPTURE;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (status.cmd)
               CMD_ADD: begin
                  if (status.count_full) begin
                     op       = OP_PUSH_FULL;
                     state_in = S_FINISH;
                  end else begin
                     state_in = S_ALLOC1;
                  end
               end
               CMD_DELETE: begin
                  if (status.handle_live) begin
                     op       = OP_READ_POS;
                     state_in = S_DEL_POS;
                  end else begin
                     op       = OP_PUSH_BAD;
                     state_in = S_FINISH;
                  end
               end
               CMD_EXPIRE: state_in = S_EXP_CHECK;
               CMD_NOP: begin
                  op       = OP_PUSH_NULL;
                  state_in = S_FINISH;
               end
               default: state_in = S_FINISH;
            endcase
         end
         S_ALLOC1: begin
            op       = OP_ALLOC_GRP;
            state_in = S_ALLOC2;
         end
         S_ALLOC2: begin
            op       = OP_ALLOC_SET;
            state_in = S_UP_READ;
         end
         S_UP_READ: begin
            op       = OP_UP_READ;
            state_in = status.hole_is_root ? S_PLACE : S_UP_CMP;
         end
         S_UP_CMP: begin
            if (status.up_less) begin
               op       = OP_MOVE_PARENT;
               state_in = S_UP_READ;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            op       = OP_PLACE;
            state_in = done_state;
         end
         S_DEL_POS: begin
            op       = OP_DEL_POS;
            state_in = S_REMOVE;
         end
         S_REMOVE: begin
            if (status.hole_lt_count) begin
               op       = OP_READ_LAST;
               state_in = S_RM_LAST;
            end else begin
               op       = OP_COUNT_DEC;
               state_in = done_state;
            end
         end
         S_RM_LAST: begin
            op       = OP_TAKE_LAST;
            state_in = status.hole_is_root ? S_DOWN_L : S_RM_PAR;
         end
         S_RM_PAR: begin
            if (status.up_less) begin
               op       = OP_MOVE_PARENT;
               state_in = S_UP_READ;
            end else begin
               state_in = S_DOWN_L;
            end
         end
         S_DOWN_L: begin
            if (status.kid_gt_count) begin
               state_in = S_PLACE;
            end else begin
               op       = OP_READ_LEFT;
               state_in = S_DOWN_R;
            end
         end
         S_DOWN_R: begin
            op       = OP_TAKE_LEFT;
            state_in = status.kid_lt_count ? S_DOWN_RC : S_DOWN_CMP;
         end
         S_DOWN_RC: begin
            op       = OP_TAKE_RIGHT;
            state_in = S_DOWN_CMP;
         end
         S_DOWN_CMP: begin
            if (status.down_stop) begin
               state_in = S_PLACE;
            end else begin
               op       = OP_MOVE_CHILD;
               state_in = S_DOWN_L;
            end
         end
         S_EXP_CHECK: begin
            if (status.count_zero || status.n_full) begin
               state_in = S_EXP_END;
            end else begin
               op       = OP_READ_ROOT;
               state_in = S_EXP_ROOT;
            end
         end
         S_EXP_ROOT: begin
            if (status.root_late) begin
               state_in = S_EXP_END;
            end else begin
               op       = OP_TAKE_ROOT;
               state_in = S_EXP_TAG;
            end
         end
         S_EXP_TAG: begin
            op       = OP_PUSH_EXPIRED;
            state_in = S_REMOVE;
         end
         S_EXP_END: begin
            if (status.n_zero) begin
               op = OP_PUSH_NONE;
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            op       = OP_READ_ROOT;
            state_in = S_FIN_KEY;
         end
         S_FIN_KEY: begin
            op       = OP_TAKE_EARLIEST;
            state_in = S_EMIT_RD;
         end
         S_EMIT_RD: begin
            op       = OP_READ_BUF;
            state_in = S_EMIT_LD;
         end
         S_EMIT_LD: begin
            op           = OP_LOAD_OUT;
            rsp_valid_in = 1'b1;
            state_in     = S_EMIT_WAIT;
         end
         S_EMIT_WAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (status.last_item) begin
                  state_in = S_IDLE;
               end else begin
                  op       = OP_NEXT_IDX;
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> src/timer_min_heap.sv
// Timer min-heap top level: joins the controller and datapath to the channels.
// Depends on tmh_pkg, tmh_if, tmh_ctrl, tmh_datapath.
`timescale 1ns / 1ps

// Binary min-heap timer queue for 64 timers, one item at a time. The heap
// lives in a RAM with one registered read port, so every sift level costs
// its memory reads: an add sifts the new entry up level by level, a delete
// moves the last entry into the hole and sifts it up or down, an expire
// pops each due timer and sifts the refilled root down. The new earliest
// time is then fetched from the root. All results of an item are buffered
// and then drained one at a time, each held until the response is taken,
// since each carries the count and earliest time after the whole item; the
// next item is taken only after the last result of the item is drained.
module timer_min_heap (
   input logic      clock,
   input logic      reset,
   tmh_req_if.sink  req_ch,
   tmh_rsp_if.source rsp_ch
);
   import tmh_pkg::*;

   dp_op_type     op;
   dp_status_type status;

   tmh_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .rsp_valid(rsp_ch.valid),
      .rsp_ready(rsp_ch.ready),
      .status   (status),
      .op       (op)
   );

   tmh_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .op               (op),
      .req_cmd          (req_ch.cmd),
      .req_expire_time  (req_ch.expire_time),
      .req_user_tag     (req_ch.user_tag),
      .req_timer_handle (req_ch.timer_handle),
      .req_now_time     (req_ch.now_time),
      .status           (status),
      .rsp_status       (rsp_ch.status),
      .rsp_result_handle(rsp_ch.result_handle),
      .rsp_expired_tag  (rsp_ch.expired_tag),
      .rsp_earliest_time(rsp_ch.earliest_time),
      .rsp_timer_count  (rsp_ch.timer_count),
      .rsp_last         (rsp_ch.last)
   );

endmodule
